// ===== src/scl_pkg.sv =====
// shared types and constants of the sector cache lru controller
package scl_pkg;

    // default sizing
    localparam int DEF_LINES       = 64;
    localparam int DEF_SECTOR_BITS = 32;
    localparam int DEF_STAMP_BITS  = 32;

    // fixed widths of result fields
    localparam int LINE_INDEX_BITS = 6;
    localparam int WB_SECTOR_BITS  = 32;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } scl_state_t;

    // flags carried by the search token from cell to cell
    typedef struct packed {
        logic valid;
        logic hit_found;
        logic free_found;
        logic vic_valid;
        logic vic_dirty;
    } probe_flags_t;

    // line update command broadcast to the cell row
    typedef struct packed {
        logic en;
        logic is_hit;
        logic is_write;
    } upd_ctl_t;

endpackage

// ===== src/scl_cell.sv =====
// one cache line cell: line state plus one stage of the search token chain
module scl_cell #(
    parameter int LINES       = scl_pkg::DEF_LINES,
    parameter int SECTOR_BITS = scl_pkg::DEF_SECTOR_BITS,
    parameter int STAMP_BITS  = scl_pkg::DEF_STAMP_BITS,
    parameter int CELL_ID     = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // current transaction, broadcast
    input  logic [SECTOR_BITS-1:0]     req_sector,
    input  logic [STAMP_BITS-1:0]      req_tick,
    // line update command
    input  scl_pkg::upd_ctl_t          upd,
    input  logic [$clog2(LINES)-1:0]   upd_idx,
    // token from the previous cell
    input  scl_pkg::probe_flags_t      flags_in,
    input  logic [$clog2(LINES)-1:0]   hit_idx_in,
    input  logic [$clog2(LINES)-1:0]   free_idx_in,
    input  logic [$clog2(LINES)-1:0]   vic_idx_in,
    input  logic [STAMP_BITS-1:0]      vic_stamp_in,
    input  logic [SECTOR_BITS-1:0]     vic_sector_in,
    // token to the next cell
    output scl_pkg::probe_flags_t      flags_out,
    output logic [$clog2(LINES)-1:0]   hit_idx_out,
    output logic [$clog2(LINES)-1:0]   free_idx_out,
    output logic [$clog2(LINES)-1:0]   vic_idx_out,
    output logic [STAMP_BITS-1:0]      vic_stamp_out,
    output logic [SECTOR_BITS-1:0]     vic_sector_out
);
    import scl_pkg::*;

    localparam int              IW     = $clog2(LINES);
    localparam logic [IW-1:0]   MY_IDX = IW'(CELL_ID);

    // line state
    logic                   busy_reg;
    logic                   dirty_reg;
    logic [SECTOR_BITS-1:0] sector_reg;
    logic [STAMP_BITS-1:0]  stamp_reg;

    // token stage
    probe_flags_t           flags_reg,      flags_next;
    logic [IW-1:0]          hit_idx_reg,    hit_idx_next;
    logic [IW-1:0]          free_idx_reg,   free_idx_next;
    logic [IW-1:0]          vic_idx_reg,    vic_idx_next;
    logic [STAMP_BITS-1:0]  vic_stamp_reg,  vic_stamp_next;
    logic [SECTOR_BITS-1:0] vic_sector_reg, vic_sector_next;

    logic                   upd_here;

    assign upd_here = upd.en && (upd_idx == MY_IDX);

    // merge this line into the token
    always_comb begin
        flags_next      = flags_in;
        hit_idx_next    = hit_idx_in;
        free_idx_next   = free_idx_in;
        vic_idx_next    = vic_idx_in;
        vic_stamp_next  = vic_stamp_in;
        vic_sector_next = vic_sector_in;
        // first busy line holding the sector
        if (!flags_in.hit_found && busy_reg && (sector_reg == req_sector)) begin
            flags_next.hit_found = 1'b1;
            hit_idx_next         = MY_IDX;
        end
        // first free line
        if (!flags_in.free_found && !busy_reg) begin
            flags_next.free_found = 1'b1;
            free_idx_next         = MY_IDX;
        end
        // least stamp, strict compare keeps the lower index on ties
        if (!flags_in.vic_valid || (stamp_reg < vic_stamp_in)) begin
            flags_next.vic_valid = 1'b1;
            flags_next.vic_dirty = dirty_reg;
            vic_idx_next         = MY_IDX;
            vic_stamp_next       = stamp_reg;
            vic_sector_next      = sector_reg;
        end
    end

    // line control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end else if (upd_here) begin
            if (upd.is_hit) begin
                dirty_reg <= dirty_reg | upd.is_write;
            end else begin
                busy_reg  <= 1'b1;
                dirty_reg <= upd.is_write;
            end
        end
    end

    // line tag and stamp
    always_ff @(posedge aclk) begin
        if (upd_here) begin
            stamp_reg <= req_tick;
            if (!upd.is_hit) begin
                sector_reg <= req_sector;
            end
        end
    end

    // token valid moves every cycle, payload holds after the token passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (flags_in.valid) begin
            flags_reg <= flags_next;
        end else begin
            flags_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (flags_in.valid) begin
            hit_idx_reg    <= hit_idx_next;
            free_idx_reg   <= free_idx_next;
            vic_idx_reg    <= vic_idx_next;
            vic_stamp_reg  <= vic_stamp_next;
            vic_sector_reg <= vic_sector_next;
        end
    end

    assign flags_out      = flags_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign free_idx_out   = free_idx_reg;
    assign vic_idx_out    = vic_idx_reg;
    assign vic_stamp_out  = vic_stamp_reg;
    assign vic_sector_out = vic_sector_reg;

endmodule

// ===== src/scl_ctrl.sv =====
// request sequencer: accepts a transaction, launches the search, builds the result
module scl_ctrl #(
    parameter int LINES       = scl_pkg::DEF_LINES,
    parameter int SECTOR_BITS = scl_pkg::DEF_SECTOR_BITS,
    parameter int STAMP_BITS  = scl_pkg::DEF_STAMP_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic [SECTOR_BITS-1:0]                 s_sector,
    input  logic [STAMP_BITS-1:0]                  s_now_tick,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_hit,
    output logic [scl_pkg::LINE_INDEX_BITS-1:0]    m_line_index,
    output logic                                   m_fetch_needed,
    output logic                                   m_writeback_needed,
    output logic [scl_pkg::WB_SECTOR_BITS-1:0]     m_writeback_sector,
    // to the cell row
    output logic [SECTOR_BITS-1:0]                 req_sector,
    output logic [STAMP_BITS-1:0]                  req_tick,
    output scl_pkg::probe_flags_t                  start_flags,
    output scl_pkg::upd_ctl_t                      upd,
    output logic [$clog2(LINES)-1:0]               upd_idx,
    // token leaving the last cell
    input  scl_pkg::probe_flags_t                  last_flags,
    input  logic [$clog2(LINES)-1:0]               last_hit_idx,
    input  logic [$clog2(LINES)-1:0]               last_free_idx,
    input  logic [$clog2(LINES)-1:0]               last_vic_idx,
    input  logic [SECTOR_BITS-1:0]                 last_vic_sector
);
    import scl_pkg::*;

    localparam int IW = $clog2(LINES);

    scl_state_t                 state_reg, state_next;

    logic                       req_write_reg;
    logic [SECTOR_BITS-1:0]     req_sector_reg;
    logic [STAMP_BITS-1:0]      req_tick_reg;
    logic                       start_reg;

    logic                       m_valid_reg;
    logic                       m_hit_reg;
    logic [LINE_INDEX_BITS-1:0] m_line_index_reg;
    logic                       m_fetch_reg;
    logic                       m_wb_reg;
    logic [WB_SECTOR_BITS-1:0]  m_wb_sector_reg;

    upd_ctl_t                   upd_reg;
    logic [IW-1:0]              upd_idx_reg;

    logic                       accept;
    logic                       out_free;
    logic                       finish_fire;
    logic [IW-1:0]              idx_sel;
    logic                       wb_sel;
    logic [IW+LINE_INDEX_BITS-1:0]         idx_ext;
    logic [SECTOR_BITS+WB_SECTOR_BITS-1:0] wb_sec_ext;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid)          state_next = ST_SCAN;
            ST_SCAN:   if (last_flags.valid) state_next = ST_FINISH;
            ST_FINISH: if (out_free)         state_next = ST_IDLE;
            default:                         state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        finish_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready     = 1'b1;
            ST_SCAN:   s_ready     = 1'b0;
            ST_FINISH: finish_fire = out_free;
            default:   s_ready     = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    // choose hit line, else first free line, else lru victim
    always_comb begin
        priority if (last_flags.hit_found) begin
            idx_sel = last_hit_idx;
        end else if (last_flags.free_found) begin
            idx_sel = last_free_idx;
        end else begin
            idx_sel = last_vic_idx;
        end
        wb_sel     = !last_flags.hit_found && !last_flags.free_found && last_flags.vic_dirty;
        idx_ext    = {{LINE_INDEX_BITS{1'b0}}, idx_sel};
        wb_sec_ext = {{WB_SECTOR_BITS{1'b0}}, last_vic_sector};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            upd_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            start_reg  <= accept;
            upd_reg.en <= finish_fire;
            if (finish_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (finish_fire) begin
                upd_reg.is_hit   <= last_flags.hit_found;
                upd_reg.is_write <= req_write_reg;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_write_reg  <= s_opcode;
            req_sector_reg <= s_sector;
            req_tick_reg   <= s_now_tick;
        end
    end

    // result register and update target
    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            m_hit_reg        <= last_flags.hit_found;
            m_line_index_reg <= idx_ext[LINE_INDEX_BITS-1:0];
            m_fetch_reg      <= !last_flags.hit_found;
            m_wb_reg         <= wb_sel;
            m_wb_sector_reg  <= wb_sel ? wb_sec_ext[WB_SECTOR_BITS-1:0] : '0;
            upd_idx_reg      <= idx_sel;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hit              = m_hit_reg;
    assign m_line_index       = m_line_index_reg;
    assign m_fetch_needed     = m_fetch_reg;
    assign m_writeback_needed = m_wb_reg;
    assign m_writeback_sector = m_wb_sector_reg;

    assign req_sector = req_sector_reg;
    assign req_tick   = req_tick_reg;
    assign upd        = upd_reg;
    assign upd_idx    = upd_idx_reg;

    // token entering cell zero
    always_comb begin
        start_flags       = '0;
        start_flags.valid = start_reg;
    end

endmodule

// ===== src/sector_cache_lru_controller_unit.sv =====
// top level of the sector cache lru controller: sequencer plus a row of line cells
//
//   channel   direction  ports                                        handshake
//   request   in         s_opcode, s_sector, s_now_tick               s_valid / s_ready
//   result    out        m_hit, m_line_index, m_fetch_needed,         m_valid / m_ready
//                        m_writeback_needed, m_writeback_sector
//
// one transaction at a time: m_valid rises once the search token has walked the cell row
// one line per cycle and the result has been registered.
// the next request is taken the cycle after the result is registered, even while
// the result still waits for m_ready; a held result stalls only the following finish.
// synchronous active-low reset frees every line and clears all dirty marks at once.
module sector_cache_lru_controller_unit #(
    parameter int LINES       = scl_pkg::DEF_LINES,
    parameter int SECTOR_BITS = scl_pkg::DEF_SECTOR_BITS,
    parameter int STAMP_BITS  = scl_pkg::DEF_STAMP_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic [SECTOR_BITS-1:0]                 s_sector,
    input  logic [STAMP_BITS-1:0]                  s_now_tick,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_hit,
    output logic [scl_pkg::LINE_INDEX_BITS-1:0]    m_line_index,
    output logic                                   m_fetch_needed,
    output logic                                   m_writeback_needed,
    output logic [scl_pkg::WB_SECTOR_BITS-1:0]     m_writeback_sector
);
    import scl_pkg::*;

    localparam int IW = $clog2(LINES);

    logic [SECTOR_BITS-1:0] req_sector;
    logic [STAMP_BITS-1:0]  req_tick;
    upd_ctl_t               upd;
    logic [IW-1:0]          upd_idx;
    probe_flags_t           start_flags;

    // token links between cells, link 0 feeds the first cell
    probe_flags_t           flags_w      [LINES+1];
    logic [IW-1:0]          hit_idx_w    [LINES+1];
    logic [IW-1:0]          free_idx_w   [LINES+1];
    logic [IW-1:0]          vic_idx_w    [LINES+1];
    logic [STAMP_BITS-1:0]  vic_stamp_w  [LINES+1];
    logic [SECTOR_BITS-1:0] vic_sector_w [LINES+1];

    assign flags_w[0]      = start_flags;
    assign hit_idx_w[0]    = '0;
    assign free_idx_w[0]   = '0;
    assign vic_idx_w[0]    = '0;
    assign vic_stamp_w[0]  = '0;
    assign vic_sector_w[0] = '0;

    // sequencer
    scl_ctrl #(
        .LINES       (LINES),
        .SECTOR_BITS (SECTOR_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_sector           (s_sector),
        .s_now_tick         (s_now_tick),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (m_hit),
        .m_line_index       (m_line_index),
        .m_fetch_needed     (m_fetch_needed),
        .m_writeback_needed (m_writeback_needed),
        .m_writeback_sector (m_writeback_sector),
        .req_sector         (req_sector),
        .req_tick           (req_tick),
        .start_flags        (start_flags),
        .upd                (upd),
        .upd_idx            (upd_idx),
        .last_flags         (flags_w[LINES]),
        .last_hit_idx       (hit_idx_w[LINES]),
        .last_free_idx      (free_idx_w[LINES]),
        .last_vic_idx       (vic_idx_w[LINES]),
        .last_vic_sector    (vic_sector_w[LINES])
    );

    // row of line cells
    for (genvar i = 0; i < LINES; i++) begin : g_cell
        scl_cell #(
            .LINES       (LINES),
            .SECTOR_BITS (SECTOR_BITS),
            .STAMP_BITS  (STAMP_BITS),
            .CELL_ID     (i)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .req_sector     (req_sector),
            .req_tick       (req_tick),
            .upd            (upd),
            .upd_idx        (upd_idx),
            .flags_in       (flags_w[i]),
            .hit_idx_in     (hit_idx_w[i]),
            .free_idx_in    (free_idx_w[i]),
            .vic_idx_in     (vic_idx_w[i]),
            .vic_stamp_in   (vic_stamp_w[i]),
            .vic_sector_in  (vic_sector_w[i]),
            .flags_out      (flags_w[i+1]),
            .hit_idx_out    (hit_idx_w[i+1]),
            .free_idx_out   (free_idx_w[i+1]),
            .vic_idx_out    (vic_idx_w[i+1]),
            .vic_stamp_out  (vic_stamp_w[i+1]),
            .vic_sector_out (vic_sector_w[i+1])
        );
    end

endmodule

// ===== src/scl_checker.sv =====
// port-level checks of the sector cache lru controller and their binding
module scl_checker #(
    parameter int SECTOR_BITS = scl_pkg::DEF_SECTOR_BITS,
    parameter int STAMP_BITS  = scl_pkg::DEF_STAMP_BITS
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   s_opcode,
    input logic [SECTOR_BITS-1:0]                 s_sector,
    input logic [STAMP_BITS-1:0]                  s_now_tick,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic                                   m_hit,
    input logic [scl_pkg::LINE_INDEX_BITS-1:0]    m_line_index,
    input logic                                   m_fetch_needed,
    input logic                                   m_writeback_needed,
    input logic [scl_pkg::WB_SECTOR_BITS-1:0]     m_writeback_sector
);
    import scl_pkg::*;

    // one transaction in flight: after an accept the request side closes
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a transaction is in flight");

    // a stalled result holds
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_line_index)
            && $stable(m_hit) && $stable(m_writeback_sector))
        else $error("result changed while stalled");

    // a fetch is asked exactly on a miss
    a_fetch_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fetch_needed != m_hit))
        else $error("fetch flag disagrees with hit");

    // a hit never evicts
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_writeback_needed)
        else $error("write-back reported on a hit");

    // write-back sector reads zero when there is no write-back
    a_wb_sector_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback_needed |-> (m_writeback_sector == '0))
        else $error("write-back sector nonzero without write-back");

endmodule

bind sector_cache_lru_controller_unit scl_checker #(
    .SECTOR_BITS (SECTOR_BITS),
    .STAMP_BITS  (STAMP_BITS)
) u_scl_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_opcode           (s_opcode),
    .s_sector           (s_sector),
    .s_now_tick         (s_now_tick),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_hit              (m_hit),
    .m_line_index       (m_line_index),
    .m_fetch_needed     (m_fetch_needed),
    .m_writeback_needed (m_writeback_needed),
    .m_writeback_sector (m_writeback_sector)
);

// ===== dv/sector_cache_lru_controller_unit_tb.sv =====
// testbench for the sector cache lru controller: random and directed lookups checked against a tag tracker
`timescale 1ns / 1ps

localparam int LINE_COUNT = scl_pkg::DEF_LINES;
localparam int SEC_W      = scl_pkg::DEF_SECTOR_BITS;
localparam int STAMP_W    = scl_pkg::DEF_STAMP_BITS;

// request opcodes
localparam bit OP_READ  = 1'b0;
localparam bit OP_WRITE = 1'b1;

// one lookup outcome as the block reports it
typedef struct packed {
    logic                                hit;
    logic [scl_pkg::LINE_INDEX_BITS-1:0] line_index;
    logic                                fetch_needed;
    logic                                writeback_needed;
    logic [scl_pkg::WB_SECTOR_BITS-1:0]  writeback_sector;
} lookup_result_t;

// mirror of the tag store with lru replacement, plus the queue of outcomes still owed
class lru_tag_tracker;
    bit               occupied [LINE_COUNT];
    bit               modified [LINE_COUNT];
    bit [SEC_W-1:0]   tag      [LINE_COUNT];
    bit [STAMP_W-1:0] last_use [LINE_COUNT];
    lookup_result_t   pending_lookups[$];
    int               mismatches;

    // work out the outcome of an accepted request and update the mirror
    function void record_request(bit is_write, bit [SEC_W-1:0] sec, bit [STAMP_W-1:0] tick);
        int             slot;
        lookup_result_t want;
        slot = -1;
        want = '0;
        for (int i = 0; i < LINE_COUNT; i++) begin
            if (slot < 0 && occupied[i] && tag[i] == sec)
                slot = i;
        end
        if (slot >= 0) begin
            // hit: refresh stamp, a write marks the line dirty
            want.hit = 1'b1;
            last_use[slot] = tick;
            if (is_write == OP_WRITE)
                modified[slot] = 1'b1;
        end else begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                if (slot < 0 && !occupied[i])
                    slot = i;
            end
            // no free line: oldest stamp wins, lowest index on ties
            if (slot < 0) begin
                slot = 0;
                for (int i = 1; i < LINE_COUNT; i++) begin
                    if (last_use[i] < last_use[slot])
                        slot = i;
                end
                if (modified[slot]) begin
                    want.writeback_needed = 1'b1;
                    want.writeback_sector = tag[slot];
                end
            end
            occupied[slot] = 1'b1;
            last_use[slot] = tick;
            tag[slot]      = sec;
            modified[slot] = (is_write == OP_WRITE);
            want.fetch_needed = 1'b1;
        end
        want.line_index = slot[scl_pkg::LINE_INDEX_BITS-1:0];
        pending_lookups.push_back(want);
    endfunction

    function void compare_field(string field, bit [63:0] want, bit [63:0] got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
        end
    endfunction

    // compare one accepted result with the oldest outstanding lookup
    function void check_result(lookup_result_t got);
        lookup_result_t want;
        if (pending_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no request outstanding, line %0d",
                         $realtime, got.line_index);
            return;
        end
        want = pending_lookups.pop_front();
        compare_field("hit", 64'(want.hit), 64'(got.hit));
        compare_field("line_index", 64'(want.line_index), 64'(got.line_index));
        compare_field("fetch_needed", 64'(want.fetch_needed), 64'(got.fetch_needed));
        compare_field("writeback_needed", 64'(want.writeback_needed),
                      64'(got.writeback_needed));
        compare_field("writeback_sector", 64'(want.writeback_sector),
                      64'(got.writeback_sector));
    endfunction
endclass

module sector_cache_lru_controller_unit_tb;

    localparam int RANDOM_ITEMS = 1200;
    localparam int DIRECTED     = 16;
    localparam int POOL_SIZE    = 96;
    // the quiet limit leaves room for a full lookup plus long stalls on both sides
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_opcode;
    logic [SEC_W-1:0]                    s_sector;
    logic [STAMP_W-1:0]                  s_now_tick;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_hit;
    logic [scl_pkg::LINE_INDEX_BITS-1:0] m_line_index;
    logic                                m_fetch_needed;
    logic                                m_writeback_needed;
    logic [scl_pkg::WB_SECTOR_BITS-1:0]  m_writeback_sector;

    lru_tag_tracker tracker;
    int             requests_taken;
    int             quiet_cycles;
    logic           calm;

    // directed lookups: extremes of sector and tick, both opcodes, hits, wrap of the tick
    bit             dir_op     [DIRECTED] = '{OP_READ, OP_WRITE, OP_READ, OP_WRITE,
                                              OP_READ, OP_WRITE, OP_READ, OP_WRITE,
                                              OP_READ, OP_READ, OP_WRITE, OP_READ,
                                              OP_WRITE, OP_READ, OP_WRITE, OP_READ};
    bit [SEC_W-1:0] dir_sector [DIRECTED] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
                                              32'h0000_0000, 32'hffff_ffff, 32'h5555_5555,
                                              32'haaaa_aaaa, 32'h8000_0000, 32'h7fff_ffff,
                                              32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa,
                                              32'h1234_5678, 32'h0000_0000, 32'h8000_0000,
                                              32'hffff_fffe};
    bit [STAMP_W-1:0] dir_tick [DIRECTED] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                                              32'h0000_0002, 32'h0000_0003, 32'haaaa_aaaa,
                                              32'h5555_5555, 32'h7fff_ffff, 32'h8000_0000,
                                              32'h0000_0001, 32'h0000_0004, 32'h0000_0004,
                                              32'hffff_fffe, 32'h0000_0000, 32'hffff_ffff,
                                              32'h0000_0010};

    sector_cache_lru_controller_unit DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_sector           (s_sector),
        .s_now_tick         (s_now_tick),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (m_hit),
        .m_line_index       (m_line_index),
        .m_fetch_needed     (m_fetch_needed),
        .m_writeback_needed (m_writeback_needed),
        .m_writeback_sector (m_writeback_sector)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // no idling on either side during a stretch in the middle of the run
    assign calm = (requests_taken >= 500) && (requests_taken < 800);

    // result side backpressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // transaction monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_result('{m_hit, m_line_index, m_fetch_needed,
                                       m_writeback_needed, m_writeback_sector});
            if (s_valid && s_ready) begin
                tracker.record_request(s_opcode, s_sector, s_now_tick);
                requests_taken <= requests_taken + 1;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // present one request, with an optional random gap before it; entered and left at a falling edge
    task automatic send_request(input bit op, input bit [SEC_W-1:0] sec,
                                input bit [STAMP_W-1:0] tick);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while (!calm && $urandom_range(0, 99) < 11);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_sector   <= sec;
        s_now_tick <= tick;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    initial begin
        bit [SEC_W-1:0]   pool [POOL_SIZE];
        bit [SEC_W-1:0]   sec;
        bit [STAMP_W-1:0] tick;
        int               span;

        tracker        = new();
        requests_taken = 0;
        quiet_cycles   = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = OP_READ;
        s_sector       = '0;
        s_now_tick     = '0;
        m_ready        = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED; i++)
            send_request(dir_op[i], dir_sector[i], dir_tick[i]);

        // random lookups over a working set that is sometimes smaller, sometimes larger than the cache
        tick = $urandom;
        span = POOL_SIZE;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 300 == 0) begin
                pool[0] = '0;
                pool[1] = '1;
                for (int k = 2; k < POOL_SIZE; k++)
                    pool[k] = $urandom;
            end
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0:       span = 12;
                    1:       span = LINE_COUNT;
                    2:       span = 72;
                    default: span = POOL_SIZE;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                sec = $urandom;
            else
                sec = pool[$urandom_range(0, span - 1)];
            // mostly rising ticks with repeats for stamp ties, plus jumps and wrap
            case ($urandom_range(0, 19))
                0:       tick = $urandom;
                1:       tick = '1 - $urandom_range(0, 3);
                2, 3:    tick = tick;
                default: tick = tick + $urandom_range(1, 3);
            endcase
            send_request(1'($urandom_range(0, 1)), sec, tick);
        end
        s_valid <= 1'b0;

        while (tracker.pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending_lookups.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/scl_pkg.sv
src/scl_cell.sv
src/scl_ctrl.sv
src/sector_cache_lru_controller_unit.sv
src/scl_checker.sv
dv/sector_cache_lru_controller_unit_tb.sv
